/* hdl/cse3d_pkg.sv */
// ----------------------------------------------------------------------------
// cse3d_pkg
// Shared widths, fixed-point constants and command codes for the 3-D
// Chebyshev series evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package cse3d_pkg;

    localparam int CFG_W     = 4;
    localparam int INDEX_W   = 9;
    localparam int COEF_W    = 32;
    localparam int COORD_W   = 16;
    localparam int OUT_W     = 42;

    // Q2.24 Chebyshev terms
    localparam int FRAC_W    = 24;
    localparam int T_W       = 26;

    // shared multiplier operands and product
    localparam int MUL_A_W   = 32;
    localparam int MUL_B_W   = 29;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;

    // recurrence: 2*x*T in Q.24 is (x15*T) >> 14
    localparam int REC_SHIFT = COORD_W - 2;
    localparam int REC_P_W   = 28;

    localparam int PXY_W     = 28;
    localparam int PXYZ_W    = MUL_B_W;
    localparam int TERM_W    = PROD_W - FRAC_W;

    localparam logic signed [T_W-1:0] ONE_Q24 = T_W'(1) <<< FRAC_W;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

endpackage

`default_nettype wire

/* hdl/cse3d_ram.sv */
// ----------------------------------------------------------------------------
// cse3d_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cse3d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* hdl/cse3d_mul.sv */
// ----------------------------------------------------------------------------
// cse3d_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module cse3d_mul (
    input  logic                                   clk,
    input  logic                                   en,
    input  logic signed [cse3d_pkg::MUL_A_W-1:0]   op_a,
    input  logic signed [cse3d_pkg::MUL_B_W-1:0]   op_b,
    output logic signed [cse3d_pkg::PROD_W-1:0]    prod
);

    import cse3d_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= op_a * op_b;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

/* hdl/chebyshev_series_eval_3d.sv */
// ----------------------------------------------------------------------------
// chebyshev_series_eval_3d
// Three-dimensional tensor-product Chebyshev series evaluator, Q18.24 out.
// ----------------------------------------------------------------------------
// A write transaction stores one Q8.24 coefficient at i*M*M + j*M + k in a
// single-port-write RAM (M = MAX_TERMS); indexes at or beyond M^3 are
// dropped. Only entries that were written may be used by an evaluation. An
// evaluate transaction builds T_0..T_{n-1} for x, y and z, then sums
// coef*Tx*Ty*Tz, where n = min(terms_in_use, M). All of it runs through
// one shared 32x29 multiplier. item_stall is high while an evaluation is
// in progress. A finished result sits in an output register, so a new
// transaction is taken while it waits. terms_in_use is written through the
// cfg channel; the user must write it only while idle, as the block does
// not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module chebyshev_series_eval_3d #(
    parameter int MAX_TERMS = 8
) (
    input  logic                                    clk,
    input  logic                                    rst_n,

    input  logic                                    item_valid,
    output logic                                    item_stall,
    input  logic                                    command,
    input  logic [cse3d_pkg::INDEX_W-1:0]           coef_index,
    input  logic signed [cse3d_pkg::COEF_W-1:0]     coef_value,
    input  logic signed [cse3d_pkg::COORD_W-1:0]    x_coord,
    input  logic signed [cse3d_pkg::COORD_W-1:0]    y_coord,
    input  logic signed [cse3d_pkg::COORD_W-1:0]    z_coord,

    output logic                                    result_valid,
    input  logic                                    result_stall,
    output logic signed [cse3d_pkg::OUT_W-1:0]      series_value,

    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [cse3d_pkg::CFG_W-1:0]             terms_in_use
);

    import cse3d_pkg::*;

    localparam int STORE_DEPTH = MAX_TERMS * MAX_TERMS * MAX_TERMS;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int IDX_W       = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int ACC_W       = OUT_W + 1 + 3 * $clog2(MAX_TERMS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_REC_ONE,
        S_REC_MUL,
        S_REC_ACC,
        S_XY_MUL,
        S_XY_SHIFT,
        S_Z_MUL,
        S_C_MUL,
        S_DRAIN,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    state_t                      state_reg, state_next;
    axis_t                       axis_reg, axis_next;
    logic [CFG_W-1:0]            terms_reg, terms_next;
    logic [CFG_W-1:0]            n_reg, n_next;
    logic [CFG_W-1:0]            rec_i_reg, rec_i_next;
    logic [CFG_W-1:0]            i_reg, i_next;
    logic [CFG_W-1:0]            j_reg, j_next;
    logic [CFG_W-1:0]            k_reg, k_next;
    logic                        acc_pend_reg, acc_pend_next;
    logic signed [ACC_W-1:0]     acc_reg, acc_next;
    logic signed [PXY_W-1:0]     pxy_reg, pxy_next;
    logic signed [T_W-1:0]       prev1_reg, prev1_next;
    logic signed [T_W-1:0]       prev2_reg, prev2_next;
    logic signed [COORD_W-1:0]   x_reg, x_next;
    logic signed [COORD_W-1:0]   y_reg, y_next;
    logic signed [COORD_W-1:0]   z_reg, z_next;
    logic signed [OUT_W-1:0]     result_reg, result_next;
    logic                        result_valid_reg, result_valid_next;

    logic signed [T_W-1:0]       t_x_reg [MAX_TERMS];
    logic signed [T_W-1:0]       t_y_reg [MAX_TERMS];
    logic signed [T_W-1:0]       t_z_reg [MAX_TERMS];

    logic                        in_accept;
    logic                        out_accept;
    logic [CFG_W-1:0]            n_limited;
    logic signed [COORD_W-1:0]   coord_sel;
    logic signed [T_W-1:0]       t_one;
    logic signed [T_W-1:0]       tx_rd, ty_rd, tz_rd;

    logic                        mul_en;
    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]    prod;
    logic signed [TERM_W-1:0]    term;
    logic signed [PXYZ_W-1:0]    pxyz;
    logic [REC_P_W-1:0]          rec_p;
    logic signed [T_W+2:0]       rec_d;
    logic signed [T_W-1:0]       rec_t;
    logic [OUT_W-1:0]            acc_sat;

    logic                        t_init;
    logic                        t_we;
    logic [IDX_W-1:0]            t_widx;
    logic signed [T_W-1:0]       t_wdata;

    logic                        ram_we;
    logic [ADDR_W-1:0]           ram_waddr;
    logic                        ram_re;
    logic [ADDR_W-1:0]           ram_raddr;
    logic [COEF_W-1:0]           ram_rdata;

    assign in_accept  = item_valid && !item_stall;
    assign out_accept = result_valid_reg && !result_stall;
    assign item_stall = (state_reg != S_IDLE);
    assign cfg_ready  = 1'b1;

    assign result_valid = result_valid_reg;
    assign series_value = result_reg;

    assign n_limited = (32'(terms_reg) > MAX_TERMS) ? CFG_W'(MAX_TERMS) : terms_reg;

    always_comb
    begin
        unique case (axis_reg)
            AXIS_X:  coord_sel = x_reg;
            AXIS_Y:  coord_sel = y_reg;
            AXIS_Z:  coord_sel = z_reg;
            default: coord_sel = x_reg;
        endcase
    end

    assign t_one = {coord_sel[COORD_W-1], coord_sel, {(FRAC_W - COORD_W + 1){1'b0}}};

    assign tx_rd = t_x_reg[i_reg[IDX_W-1:0]];
    assign ty_rd = t_y_reg[j_reg[IDX_W-1:0]];
    assign tz_rd = t_z_reg[k_reg[IDX_W-1:0]];

    assign term  = prod[PROD_W-1:FRAC_W];
    assign pxyz  = prod[FRAC_W+PXYZ_W-1:FRAC_W];
    assign rec_p = prod[REC_SHIFT+REC_P_W-1:REC_SHIFT];
    assign rec_d = $signed({rec_p[REC_P_W-1], rec_p})
                 - $signed({{3{prev2_reg[T_W-1]}}, prev2_reg});

    always_comb
    begin
        if ((&rec_d[T_W+2:T_W-1]) || !(|rec_d[T_W+2:T_W-1]))
        begin
            rec_t = rec_d[T_W-1:0];
        end
        else
        begin
            rec_t = {rec_d[T_W+2], {(T_W-1){!rec_d[T_W+2]}}};
        end
    end

    always_comb
    begin
        if ((&acc_reg[ACC_W-1:OUT_W-1]) || !(|acc_reg[ACC_W-1:OUT_W-1]))
        begin
            acc_sat = acc_reg[OUT_W-1:0];
        end
        else
        begin
            acc_sat = {acc_reg[ACC_W-1], {(OUT_W-1){!acc_reg[ACC_W-1]}}};
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        unique case (state_reg)
            S_REC_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = {{(MUL_A_W-T_W){prev1_reg[T_W-1]}}, prev1_reg};
                mul_b  = {{(MUL_B_W-COORD_W){coord_sel[COORD_W-1]}}, coord_sel};
            end
            S_XY_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = {{(MUL_A_W-T_W){tx_rd[T_W-1]}}, tx_rd};
                mul_b  = {{(MUL_B_W-T_W){ty_rd[T_W-1]}}, ty_rd};
            end
            S_Z_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = {{(MUL_A_W-PXY_W){pxy_reg[PXY_W-1]}}, pxy_reg};
                mul_b  = {{(MUL_B_W-T_W){tz_rd[T_W-1]}}, tz_rd};
            end
            S_C_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = ram_rdata;
                mul_b  = pxyz;
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    cse3d_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    assign ram_we    = in_accept && (command == CMD_WRITE)
                       && (32'(coef_index) < STORE_DEPTH);
    assign ram_waddr = ADDR_W'(coef_index);
    assign ram_re    = (state_reg == S_Z_MUL);
    assign ram_raddr = ADDR_W'((32'(i_reg) * MAX_TERMS + 32'(j_reg)) * MAX_TERMS
                               + 32'(k_reg));

    cse3d_ram #(
        .WIDTH (COEF_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (coef_value),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Chebyshev term banks
    assign t_init  = (state_reg == S_INIT);
    assign t_we    = (state_reg == S_REC_ONE) || (state_reg == S_REC_ACC);
    assign t_widx  = rec_i_reg[IDX_W-1:0];
    assign t_wdata = (state_reg == S_REC_ONE) ? t_one : rec_t;

    always_ff @(posedge clk)
    begin
        if (t_init)
        begin
            t_x_reg[0] <= ONE_Q24;
            t_y_reg[0] <= ONE_Q24;
            t_z_reg[0] <= ONE_Q24;
        end
        else if (t_we)
        begin
            unique case (axis_reg)
                AXIS_X:  t_x_reg[t_widx] <= t_wdata;
                AXIS_Y:  t_y_reg[t_widx] <= t_wdata;
                AXIS_Z:  t_z_reg[t_widx] <= t_wdata;
                default: t_x_reg[t_widx] <= t_wdata;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        axis_next         = axis_reg;
        terms_next        = terms_reg;
        n_next            = n_reg;
        rec_i_next        = rec_i_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        k_next            = k_reg;
        acc_pend_next     = acc_pend_reg;
        acc_next          = acc_reg;
        pxy_next          = pxy_reg;
        prev1_next        = prev1_reg;
        prev2_next        = prev2_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        z_next            = z_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;

        if (cfg_valid && cfg_ready)
        begin
            terms_next = terms_in_use;
        end

        if (out_accept)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (command == CMD_EVAL))
                begin
                    x_next        = x_coord;
                    y_next        = y_coord;
                    z_next        = z_coord;
                    n_next        = n_limited;
                    acc_next      = '0;
                    acc_pend_next = 1'b0;
                    i_next        = '0;
                    j_next        = '0;
                    k_next        = '0;
                    axis_next     = AXIS_X;
                    rec_i_next    = CFG_W'(1);
                    state_next    = (n_limited == '0) ? S_DONE : S_INIT;
                end
            end
            S_INIT:
            begin
                state_next = (n_reg == CFG_W'(1)) ? S_XY_MUL : S_REC_ONE;
            end
            S_REC_ONE:
            begin
                prev2_next = ONE_Q24;
                prev1_next = t_one;
                if (n_reg == CFG_W'(2))
                begin
                    rec_i_next = CFG_W'(1);
                    if (axis_reg == AXIS_Z)
                    begin
                        state_next = S_XY_MUL;
                    end
                    else
                    begin
                        axis_next  = (axis_reg == AXIS_X) ? AXIS_Y : AXIS_Z;
                        state_next = S_REC_ONE;
                    end
                end
                else
                begin
                    rec_i_next = CFG_W'(2);
                    state_next = S_REC_MUL;
                end
            end
            S_REC_MUL:
            begin
                state_next = S_REC_ACC;
            end
            S_REC_ACC:
            begin
                prev2_next = prev1_reg;
                prev1_next = rec_t;
                if (rec_i_reg == n_reg - CFG_W'(1))
                begin
                    rec_i_next = CFG_W'(1);
                    if (axis_reg == AXIS_Z)
                    begin
                        state_next = S_XY_MUL;
                    end
                    else
                    begin
                        axis_next  = (axis_reg == AXIS_X) ? AXIS_Y : AXIS_Z;
                        state_next = S_REC_ONE;
                    end
                end
                else
                begin
                    rec_i_next = rec_i_reg + CFG_W'(1);
                    state_next = S_REC_MUL;
                end
            end
            S_XY_MUL:
            begin
                if (acc_pend_reg)
                begin
                    acc_next = acc_reg + {{(ACC_W-TERM_W){term[TERM_W-1]}}, term};
                end
                acc_pend_next = 1'b0;
                state_next    = S_XY_SHIFT;
            end
            S_XY_SHIFT:
            begin
                pxy_next   = prod[FRAC_W+PXY_W-1:FRAC_W];
                k_next     = '0;
                state_next = S_Z_MUL;
            end
            S_Z_MUL:
            begin
                if (acc_pend_reg)
                begin
                    acc_next = acc_reg + {{(ACC_W-TERM_W){term[TERM_W-1]}}, term};
                end
                acc_pend_next = 1'b0;
                state_next    = S_C_MUL;
            end
            S_C_MUL:
            begin
                acc_pend_next = 1'b1;
                if (k_reg == n_reg - CFG_W'(1))
                begin
                    k_next = '0;
                    if (j_reg == n_reg - CFG_W'(1))
                    begin
                        j_next = '0;
                        if (i_reg == n_reg - CFG_W'(1))
                        begin
                            state_next = S_DRAIN;
                        end
                        else
                        begin
                            i_next     = i_reg + CFG_W'(1);
                            state_next = S_XY_MUL;
                        end
                    end
                    else
                    begin
                        j_next     = j_reg + CFG_W'(1);
                        state_next = S_XY_MUL;
                    end
                end
                else
                begin
                    k_next     = k_reg + CFG_W'(1);
                    state_next = S_Z_MUL;
                end
            end
            S_DRAIN:
            begin
                acc_next      = acc_reg + {{(ACC_W-TERM_W){term[TERM_W-1]}}, term};
                acc_pend_next = 1'b0;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_next       = acc_sat;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            axis_reg         <= AXIS_X;
            terms_reg        <= CFG_W'(8);
            n_reg            <= '0;
            rec_i_reg        <= '0;
            i_reg            <= '0;
            j_reg            <= '0;
            k_reg            <= '0;
            acc_pend_reg     <= 1'b0;
            acc_reg          <= '0;
            pxy_reg          <= '0;
            prev1_reg        <= '0;
            prev2_reg        <= '0;
            x_reg            <= '0;
            y_reg            <= '0;
            z_reg            <= '0;
            result_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            axis_reg         <= axis_next;
            terms_reg        <= terms_next;
            n_reg            <= n_next;
            rec_i_reg        <= rec_i_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            k_reg            <= k_next;
            acc_pend_reg     <= acc_pend_next;
            acc_reg          <= acc_next;
            pxy_reg          <= pxy_next;
            prev1_reg        <= prev1_next;
            prev2_reg        <= prev2_next;
            x_reg            <= x_next;
            y_reg            <= y_next;
            z_reg            <= z_next;
            result_reg       <= result_next;
            result_valid_reg <= result_valid_next;
        end
    end

    a_eval_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (command == CMD_EVAL)) |=> (state_reg != S_IDLE))
        else $error("evaluate transaction did not start the sequencer");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result loaded outside the done state");

    a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_Z_MUL) || (state_reg == S_C_MUL))
            |-> ((n_reg != '0) && (k_reg < n_reg) && (j_reg < n_reg) && (i_reg < n_reg)))
        else $error("summation index beyond terms in use");

    a_no_pending_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !acc_pend_reg)
        else $error("product left unaccumulated");

endmodule

`default_nettype wire
